@@ rtl/aik_pkg.sv @@
// Shared types, constants and helper functions for the arm inverse kinematics block.
package aik_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TAB_LEN          = 24;
    localparam int VEC_W            = 48;
    localparam int ANG_W            = 32;
    localparam int SQ_IN_W          = 64;
    localparam int SQ_OUT_W         = 32;

    localparam logic signed [ANG_W-1:0] DEG90  = 32'sd94371840;
    localparam logic signed [ANG_W-1:0] DEG180 = 32'sd188743680;
    localparam logic signed [32:0]      KGAIN  = 33'sd652032874;

    localparam logic [1:0] CFG_UPPER_LINK = 2'd0;
    localparam logic [1:0] CFG_LOWER_LINK = 2'd1;
    localparam logic [1:0] CFG_WRIST      = 2'd2;
    localparam logic [1:0] CFG_REACH      = 2'd3;

    localparam logic [12:0] UPPER_LINK_RST = 13'd2592;
    localparam logic [12:0] LOWER_LINK_RST = 13'd2592;
    localparam logic [12:0] WRIST_RST      = 13'd1960;
    localparam logic [13:0] REACH_RST      = 14'd5184;

    localparam logic signed [15:0] HELD_BASE_RST     = 16'sd0;
    localparam logic signed [15:0] HELD_SHOULDER_RST = 16'sd5760;
    localparam logic signed [15:0] HELD_ELBOW_RST    = -16'sd2240;

    typedef struct packed {
        logic start;
        logic rotate;
    } t_cordic_cmd;

    function automatic logic signed [ANG_W-1:0] atan_val(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            5'd0:    v = 32'sd47185920;
            5'd1:    v = 32'sd27855475;
            5'd2:    v = 32'sd14718068;
            5'd3:    v = 32'sd7471121;
            5'd4:    v = 32'sd3750058;
            5'd5:    v = 32'sd1876857;
            5'd6:    v = 32'sd938658;
            5'd7:    v = 32'sd469357;
            5'd8:    v = 32'sd234682;
            5'd9:    v = 32'sd117342;
            5'd10:   v = 32'sd58671;
            5'd11:   v = 32'sd29335;
            5'd12:   v = 32'sd14668;
            5'd13:   v = 32'sd7334;
            5'd14:   v = 32'sd3667;
            5'd15:   v = 32'sd1833;
            5'd16:   v = 32'sd917;
            5'd17:   v = 32'sd458;
            5'd18:   v = 32'sd229;
            5'd19:   v = 32'sd115;
            5'd20:   v = 32'sd57;
            5'd21:   v = 32'sd29;
            5'd22:   v = 32'sd14;
            5'd23:   v = 32'sd7;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // 2^-20 degree to 1/64 degree, round half up
    function automatic logic signed [15:0] to_out(input logic signed [ANG_W-1:0] t);
        logic signed [ANG_W:0] s;
        s = 33'(t) + 33'sd8192;
        return s[29:14];
    endfunction

endpackage

@@ rtl/aik_sqrt.sv @@
// Iterative floor square root, one result bit per cycle.
module aik_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [aik_pkg::SQ_IN_W-1:0]   i_radicand,
    output logic                          o_done,
    output logic [aik_pkg::SQ_OUT_W-1:0]  o_root
);
    localparam int RW = aik_pkg::SQ_OUT_W + 4;

    logic                          r_busy;
    logic                          r_done;
    logic [4:0]                    r_cnt;
    logic [aik_pkg::SQ_IN_W-1:0]   r_rad;
    logic [RW-1:0]                 r_rem;
    logic [aik_pkg::SQ_OUT_W-1:0]  r_root;
    logic [RW-1:0]                 rem_sh;
    logic [RW-1:0]                 trial;
    logic                          ge;

    assign rem_sh = {r_rem[RW-3:0], r_rad[aik_pkg::SQ_IN_W-1 -: 2]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(aik_pkg::SQ_OUT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[aik_pkg::SQ_IN_W-3:0], 2'b00};
            r_rem  <= ge ? rem_sh - trial : rem_sh;
            r_root <= {r_root[aik_pkg::SQ_OUT_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ rtl/aik_cordic.sv @@
// Iterative CORDIC unit: vectoring with pre-normalization, or rotation.
module aik_cordic #(
    parameter int CORDIC_STEPS = aik_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  aik_pkg::t_cordic_cmd               i_cmd,
    input  logic signed [aik_pkg::VEC_W-1:0]   i_x,
    input  logic signed [aik_pkg::VEC_W-1:0]   i_y,
    input  logic signed [aik_pkg::ANG_W-1:0]   i_theta,
    output logic                               o_done,
    output logic signed [aik_pkg::VEC_W-1:0]   o_x,
    output logic signed [aik_pkg::ANG_W-1:0]   o_angle
);
    localparam int N = (CORDIC_STEPS < aik_pkg::TAB_LEN) ? CORDIC_STEPS : aik_pkg::TAB_LEN;
    localparam logic signed [aik_pkg::VEC_W-1:0] LIM40 = 48'sh0100_0000_0000;
    localparam logic signed [aik_pkg::VEC_W-1:0] LIM32 = 48'sh0000_0001_0000_0000;

    typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER} t_cstate;

    t_cstate                            r_state;
    logic                               r_done;
    logic                               r_rot;
    logic [4:0]                         r_i;
    logic signed [aik_pkg::VEC_W-1:0]   r_x;
    logic signed [aik_pkg::VEC_W-1:0]   r_y;
    logic signed [aik_pkg::ANG_W-1:0]   r_z;
    logic signed [aik_pkg::VEC_W-1:0]   xs;
    logic signed [aik_pkg::VEC_W-1:0]   ys;
    logic                               up;
    logic                               small40;
    logic                               small32;

    assign xs      = r_x >>> r_i;
    assign ys      = r_y >>> r_i;
    assign up      = r_rot ? (r_z >= 0) : (r_y < 0);
    assign small40 = (r_x < LIM40) && (r_x > -LIM40) && (r_y < LIM40) && (r_y > -LIM40);
    assign small32 = (r_x < LIM32) && (r_x > -LIM32) && (r_y < LIM32) && (r_y > -LIM32);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_cmd.start) begin
                        if (i_cmd.rotate) begin
                            r_state <= C_ITER;
                        end else if (i_x == 0 && i_y == 0) begin
                            r_done <= 1'b1;
                        end else begin
                            r_state <= C_NORM;
                        end
                    end
                end
                C_NORM: begin
                    if (!small40) begin
                        r_state <= C_ITER;
                    end
                end
                C_ITER: begin
                    if (r_i == 5'(N - 1)) begin
                        r_state <= C_IDLE;
                        r_done  <= 1'b1;
                    end
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == C_IDLE && i_cmd.start) begin
            r_rot <= i_cmd.rotate;
            r_x   <= i_x;
            r_y   <= i_y;
            r_z   <= i_cmd.rotate ? i_theta : '0;
            r_i   <= '0;
        end else if (r_state == C_NORM && small40) begin
            if (small32) begin
                r_x <= r_x <<< 8;
                r_y <= r_y <<< 8;
            end else begin
                r_x <= r_x <<< 1;
                r_y <= r_y <<< 1;
            end
        end else if (r_state == C_ITER) begin
            r_i <= r_i + 5'd1;
            if (up) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - aik_pkg::atan_val(r_i);
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + aik_pkg::atan_val(r_i);
            end
        end
    end

    assign o_done  = r_done;
    assign o_x     = r_x;
    assign o_angle = r_z;

endmodule

@@ rtl/arm_inverse_kinematics_top.sv @@
// Top level: sequencer, shared multiplier and joint angle storage for the arm solver.
// A target (x, y, z) is taken when start is high and busy is low; busy stays high
// while the point is solved. An out-of-reach point returns with the held angles and
// o_reachable low. The time for a reachable point is set by three passes of the
// square root unit and five passes of the CORDIC unit (CORDIC_STEPS iterations each,
// capped at TAB_LEN, plus normalization when vectoring and the handshake states); it
// is shorter when x is zero, when x and y are both zero, or when an arccos argument
// clamps. The result is flagged for one cycle with o_done high and cannot be held
// off; the angles stay on the outputs until the next result. busy is low in that
// cycle and a new start is taken.
module arm_inverse_kinematics_top #(
    parameter int CORDIC_STEPS = aik_pkg::CORDIC_STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [13:0] i_target_x,
    input  logic signed [13:0] i_target_y,
    input  logic signed [13:0] i_target_z,
    input  logic               i_cfg_wr_en,
    input  logic [1:0]         i_cfg_index,
    input  logic [13:0]        i_cfg_data,
    output logic               o_done,
    output logic signed [15:0] o_base_angle,
    output logic signed [15:0] o_shoulder_angle,
    output logic signed [15:0] o_elbow_angle,
    output logic               o_reachable,
    output logic               o_clamped
);
    localparam int AW = aik_pkg::ANG_W;
    localparam int VW = aik_pkg::VEC_W;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_SQW, S_SQL, S_CHK, S_L2, S_DEN, S_NUM, S_ASQ,
        S_BASEW, S_BETA, S_BETAW, S_ACSQ, S_ACCMP, S_ACRT, S_ACVEC, S_ACEND,
        S_RED, S_GAIN, S_ROTS, S_ROTW, S_STORE
    } t_state;

    typedef logic signed [32:0] t_mop;

    t_state                r_state;
    logic                  r_done;
    logic                  r_reach;
    logic                  r_clamp;
    logic                  r_second;
    logic                  r_neg;
    logic [12:0]           r_upper;
    logic [12:0]           r_lower;
    logic [12:0]           r_wrist;
    logic [13:0]           r_limit;
    logic signed [15:0]    r_hb;
    logic signed [15:0]    r_hs;
    logic signed [15:0]    r_he;
    logic signed [13:0]    r_x;
    logic signed [13:0]    r_y;
    logic signed [13:0]    r_z;
    logic signed [14:0]    r_w;
    logic [27:0]           r_a2;
    logic [28:0]           r_r2;
    logic [25:0]           r_l3sq;
    logic [25:0]           r_l2sq;
    logic signed [31:0]    r_acn;
    logic [57:0]           r_acd;
    logic [29:0]           r_af;
    logic signed [AW-1:0]  r_base;
    logic signed [AW-1:0]  r_beta;
    logic signed [AW-1:0]  r_sh;
    logic signed [AW-1:0]  r_el;
    logic signed [AW-1:0]  r_ang;
    logic signed [AW-1:0]  r_th;
    logic [63:0]           r_prod;
    logic                  r_sq_start;
    logic [63:0]           r_sq_in;
    aik_pkg::t_cordic_cmd  r_ccmd;
    logic signed [VW-1:0]  r_cx;
    logic signed [VW-1:0]  r_cy;
    logic signed [AW-1:0]  r_cth;

    t_mop                  mul_a;
    t_mop                  mul_b;
    logic signed [65:0]    mul_p;
    logic signed [32:0]    acn_abs;
    logic signed [VW-1:0]  xc;
    logic signed [VW-1:0]  num2;

    logic                  sq_done;
    logic [31:0]           sq_root;
    logic                  c_done;
    logic signed [VW-1:0]  c_x;
    logic signed [AW-1:0]  c_angle;

    aik_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sq_start),
        .i_radicand (r_sq_in),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    aik_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (r_ccmd),
        .i_x     (r_cx),
        .i_y     (r_cy),
        .i_theta (r_cth),
        .o_done  (c_done),
        .o_x     (c_x),
        .o_angle (c_angle)
    );

    assign acn_abs = (r_acn < 0) ? -33'(r_acn) : 33'(r_acn);
    assign xc      = r_neg ? -c_x : c_x;
    assign num2    = VW'({18'b0, r_af}) - xc;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQX:   begin mul_a = t_mop'(r_x); mul_b = t_mop'(r_x); end
            S_SQY:   begin mul_a = t_mop'(r_y); mul_b = t_mop'(r_y); end
            S_SQW:   begin mul_a = t_mop'(r_w); mul_b = t_mop'(r_w); end
            S_SQL:   begin mul_a = {19'b0, r_limit}; mul_b = {19'b0, r_limit}; end
            S_CHK:   begin mul_a = {20'b0, r_lower}; mul_b = {20'b0, r_lower}; end
            S_L2:    begin mul_a = {20'b0, r_upper}; mul_b = {20'b0, r_upper}; end
            S_DEN:   begin mul_a = {7'b0, r_l3sq}; mul_b = {4'b0, r_r2}; end
            S_ACSQ:  begin mul_a = acn_abs; mul_b = acn_abs; end
            S_GAIN:  begin mul_a = {4'b0, r_lower, 16'b0}; mul_b = aik_pkg::KGAIN; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_reach    <= 1'b0;
            r_clamp    <= 1'b0;
            r_sq_start <= 1'b0;
            r_ccmd     <= '0;
            r_upper    <= aik_pkg::UPPER_LINK_RST;
            r_lower    <= aik_pkg::LOWER_LINK_RST;
            r_wrist    <= aik_pkg::WRIST_RST;
            r_limit    <= aik_pkg::REACH_RST;
            r_hb       <= aik_pkg::HELD_BASE_RST;
            r_hs       <= aik_pkg::HELD_SHOULDER_RST;
            r_he       <= aik_pkg::HELD_ELBOW_RST;
        end else begin
            r_done     <= 1'b0;
            r_sq_start <= 1'b0;
            r_ccmd     <= '0;
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    aik_pkg::CFG_UPPER_LINK: r_upper <= i_cfg_data[12:0];
                    aik_pkg::CFG_LOWER_LINK: r_lower <= i_cfg_data[12:0];
                    aik_pkg::CFG_WRIST:      r_wrist <= i_cfg_data[12:0];
                    aik_pkg::CFG_REACH:      r_limit <= i_cfg_data;
                    default:                 r_limit <= r_limit;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_x     <= i_target_x;
                        r_y     <= i_target_y;
                        r_z     <= i_target_z;
                        r_w     <= 15'(i_target_z) + $signed({2'b0, r_wrist});
                        r_clamp <= 1'b0;
                        r_state <= S_SQX;
                    end
                end
                S_SQX: r_state <= S_SQY;
                S_SQY: begin
                    r_a2    <= r_prod[27:0];
                    r_state <= S_SQW;
                end
                S_SQW: begin
                    r_a2    <= r_a2 + r_prod[27:0];
                    r_state <= S_SQL;
                end
                S_SQL: begin
                    r_r2    <= {1'b0, r_a2} + r_prod[28:0];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_r2 <= {1'b0, r_prod[27:0]}) begin
                        r_state <= S_L2;
                    end else begin
                        r_reach <= 1'b0;
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_L2: begin
                    r_l3sq  <= r_prod[25:0];
                    r_state <= S_DEN;
                end
                S_DEN: begin
                    r_l2sq  <= r_prod[25:0];
                    r_state <= S_NUM;
                end
                S_NUM: begin
                    r_acd      <= {r_prod[55:0], 2'b00};
                    r_acn      <= $signed({3'b0, r_r2}) + $signed({6'b0, r_l3sq})
                                  - $signed({6'b0, r_l2sq});
                    r_second   <= 1'b0;
                    r_sq_in    <= {4'b0, r_a2, 32'b0};
                    r_sq_start <= 1'b1;
                    r_state    <= S_ASQ;
                end
                S_ASQ: begin
                    if (sq_done) begin
                        r_af <= sq_root[29:0];
                        if (r_x == 0) begin
                            r_base  <= (r_y >= 0) ? aik_pkg::DEG90 : -aik_pkg::DEG90;
                            r_state <= S_BETA;
                        end else begin
                            r_cx         <= (r_x > 0) ? VW'(r_x) : -VW'(r_x);
                            r_cy         <= (r_x > 0) ? VW'(r_y) : -VW'(r_y);
                            r_ccmd.start <= 1'b1;
                            r_state      <= S_BASEW;
                        end
                    end
                end
                S_BASEW: begin
                    if (c_done) begin
                        r_base  <= c_angle;
                        r_state <= S_BETA;
                    end
                end
                S_BETA: begin
                    if (r_a2 == 0) begin
                        r_beta  <= (r_w >= 0) ? aik_pkg::DEG90 : -aik_pkg::DEG90;
                        r_state <= S_ACSQ;
                    end else begin
                        r_cx         <= VW'({18'b0, r_af});
                        r_cy         <= VW'($signed({r_w, 16'b0}));
                        r_ccmd.start <= 1'b1;
                        r_state      <= S_BETAW;
                    end
                end
                S_BETAW: begin
                    if (c_done) begin
                        r_beta  <= c_angle;
                        r_state <= S_ACSQ;
                    end
                end
                S_ACSQ: r_state <= S_ACCMP;
                S_ACCMP: begin
                    if (r_acd == 0 || r_prod > {6'b0, r_acd}) begin
                        r_clamp <= 1'b1;
                        r_ang   <= (r_acn >= 0) ? '0 : aik_pkg::DEG180;
                        r_state <= S_ACEND;
                    end else begin
                        r_sq_in    <= {6'b0, r_acd - r_prod[57:0]};
                        r_sq_start <= 1'b1;
                        r_state    <= S_ACRT;
                    end
                end
                S_ACRT: begin
                    if (sq_done) begin
                        if (r_acn >= 0) begin
                            r_cx <= VW'(r_acn);
                            r_cy <= VW'({1'b0, sq_root});
                        end else begin
                            r_cx <= VW'({1'b0, sq_root});
                            r_cy <= -VW'(r_acn);
                        end
                        r_ccmd.start <= 1'b1;
                        r_state      <= S_ACVEC;
                    end
                end
                S_ACVEC: begin
                    if (c_done) begin
                        r_ang   <= (r_acn < 0) ? c_angle + aik_pkg::DEG90 : c_angle;
                        r_state <= S_ACEND;
                    end
                end
                S_ACEND: begin
                    if (!r_second) begin
                        r_sh    <= r_ang + r_beta;
                        r_th    <= r_ang + r_beta;
                        r_neg   <= 1'b0;
                        r_state <= S_RED;
                    end else begin
                        r_el    <= (r_z < 0) ? -r_ang : r_ang;
                        r_state <= S_STORE;
                    end
                end
                S_RED: begin
                    priority if (r_th > aik_pkg::DEG90) begin
                        r_th  <= r_th - aik_pkg::DEG180;
                        r_neg <= ~r_neg;
                    end else if (r_th < -aik_pkg::DEG90) begin
                        r_th  <= r_th + aik_pkg::DEG180;
                        r_neg <= ~r_neg;
                    end else begin
                        r_state <= S_GAIN;
                    end
                end
                S_GAIN: r_state <= S_ROTS;
                S_ROTS: begin
                    r_cx          <= VW'({14'b0, r_prod[63:30]});
                    r_cy          <= '0;
                    r_cth         <= r_th;
                    r_ccmd.start  <= 1'b1;
                    r_ccmd.rotate <= 1'b1;
                    r_state       <= S_ROTW;
                end
                S_ROTW: begin
                    if (c_done) begin
                        r_acn    <= num2[31:0];
                        r_acd    <= {r_l2sq, 32'b0};
                        r_second <= 1'b1;
                        r_state  <= S_ACSQ;
                    end
                end
                S_STORE: begin
                    r_hb    <= aik_pkg::to_out(r_base);
                    r_hs    <= aik_pkg::to_out(r_sh);
                    r_he    <= aik_pkg::to_out(r_el);
                    r_reach <= 1'b1;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_base_angle     = r_hb;
    assign o_shoulder_angle = r_hs;
    assign o_elbow_angle    = r_he;
    assign o_reachable      = r_reach;
    assign o_clamped        = r_clamp;

endmodule
